### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at each rising edge, skipped while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");

// Checked at each rising edge, also during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

### rtl/rmdc_pkg.sv
// Types and constants for the rational multiply, divide and compare block.
package rmdc_pkg;

  localparam int DEFAULT_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_CMP = 2'd2,
    OP_RSV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] left_num;
    logic signed [31:0] left_den;
    logic signed [31:0] right_num;
    logic signed [31:0] right_den;
  } operand_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic signed [31:0] result_den;
    logic               is_less;
    logic               is_equal;
  } result_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULN,
    S_MULD,
    S_GCDCHK,
    S_REMB,
    S_REMA,
    S_DIVN,
    S_DIVD,
    S_CDIVG,
    S_CMULM,
    S_CDIVL,
    S_CMULA,
    S_CDIVR,
    S_CMULB,
    S_OUT
  } state_t;

endpackage

### rtl/rational_mul_div_compare.sv
// Rational multiply, divide and compare: sequencer around one shared serial unit.
//
//  channel  | valid          | stall          | payload
//  ---------+----------------+----------------+----------------------
//  operand  | operand_valid  | operand_stall  | operand (operand_t)
//  result   | result_valid   | result_stall   | result  (result_t)
//
// Multiply: 2 products, Euclid steps (data dependent), 2 quotients.
// Divide runs the reduction twice; compare runs Euclid steps, then 3 quotients and 3 products.
// Synchronous reset clears the sequencer and the result valid flag.
// A stalled result holds; a new transaction is taken once the sequencer is idle.
module rational_mul_div_compare import rmdc_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     operand_valid,
  output logic     operand_stall,
  input  operand_t operand,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  typedef logic [WIDTH-1:0] word_t;

  state_t   state;
  state_t   state_next;
  op_t      op;
  logic     pass;
  logic     pend;
  word_t    ln, ld, rn, rd;
  word_t    xa, xb, n, d, g, t, m;
  word_t    alu_a, alu_b, alu_q, alu_r;
  word_t    in_ln, in_ld, in_rn, in_rd;
  word_t    dfix;
  word_t    dneg;
  logic     alu_done;
  alu_req_t alu_req;
  logic     work;
  logic     accept;
  logic     out_free;

  function automatic word_t fix(input word_t x);
    return (x == '0) ? word_t'(1) : x;
  endfunction

  function automatic word_t from32(input logic [31:0] x);
    logic [63:0] e;
    e = 64'(signed'(x));
    return e[WIDTH-1:0];
  endfunction

  function automatic logic [31:0] to32(input word_t x);
    logic [63:0] e;
    e = 64'(signed'(x));
    return e[31:0];
  endfunction

  assign in_ln         = from32(operand.left_num);
  assign in_ld         = fix(from32(operand.left_den));
  assign in_rn         = from32(operand.right_num);
  assign in_rd         = fix(from32(operand.right_den));
  assign operand_stall = rst || (state != S_IDLE);
  assign accept        = operand_valid && !operand_stall;
  assign out_free      = !result_valid || !result_stall;
  assign dfix          = fix(alu_q);
  assign dneg          = fix(-dfix);

  rmdc_alu #(.WIDTH(WIDTH)) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .q    (alu_q),
    .r    (alu_r)
  );

  always_comb begin
    work  = 1'b1;
    alu_a = alu_q;
    alu_b = alu_q;
    case (state)
      S_MULN: begin
        alu_a = ln;
        alu_b = (op == OP_MUL) ? rn : rd;
      end
      S_MULD: begin
        alu_a = ld;
        alu_b = (op == OP_MUL) ? rd : fix(rn);
      end
      S_REMB: begin
        alu_a = xb;
        alu_b = xa;
      end
      S_REMA: begin
        alu_a = xa;
        alu_b = xb;
      end
      S_DIVN: begin
        alu_a = n;
        alu_b = g;
      end
      S_DIVD: begin
        alu_a = d;
        alu_b = g;
      end
      S_CDIVG: begin
        alu_a = ld;
        alu_b = g;
      end
      S_CMULM: begin
        alu_a = t;
        alu_b = rd;
      end
      S_CDIVL: begin
        alu_a = m;
        alu_b = ld;
      end
      S_CMULA: begin
        alu_a = ln;
        alu_b = t;
      end
      S_CDIVR: begin
        alu_a = m;
        alu_b = rd;
      end
      S_CMULB: begin
        alu_a = rn;
        alu_b = t;
      end
      default: work = 1'b0;
    endcase
    alu_req.start = work && !pend;
    case (state)
      S_MULN, S_MULD, S_CMULM, S_CMULA, S_CMULB: alu_req.op = ALU_MUL;
      default:                                   alu_req.op = ALU_DIV;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operand.operation)
            OP_MUL, OP_DIV: state_next = S_MULN;
            OP_CMP:         state_next = (in_ld == in_rd) ? S_OUT : S_GCDCHK;
            default:        state_next = S_OUT;
          endcase
        end
      end
      S_MULN:   if (alu_done) state_next = S_MULD;
      S_MULD:   if (alu_done) state_next = S_GCDCHK;
      S_GCDCHK: begin
        if (xa != '0) begin
          state_next = S_REMB;
        end else begin
          state_next = (op == OP_CMP) ? S_CDIVG : S_DIVN;
        end
      end
      S_REMB: begin
        if (alu_done) begin
          if (alu_r != '0) begin
            state_next = S_REMA;
          end else begin
            state_next = (op == OP_CMP) ? S_CDIVG : S_DIVN;
          end
        end
      end
      S_REMA:   if (alu_done) state_next = S_GCDCHK;
      S_DIVN:   if (alu_done) state_next = S_DIVD;
      S_DIVD: begin
        if (alu_done) begin
          state_next = (op == OP_DIV && !pass) ? S_GCDCHK : S_OUT;
        end
      end
      S_CDIVG:  if (alu_done) state_next = S_CMULM;
      S_CMULM:  if (alu_done) state_next = S_CDIVL;
      S_CDIVL:  if (alu_done) state_next = S_CMULA;
      S_CMULA:  if (alu_done) state_next = S_CDIVR;
      S_CDIVR:  if (alu_done) state_next = S_CMULB;
      S_CMULB:  if (alu_done) state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (alu_done) begin
        pend <= 1'b0;
      end else if (alu_req.start) begin
        pend <= 1'b1;
      end
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op   <= operand.operation;
        pass <= 1'b0;
        ln   <= in_ln;
        ld   <= in_ld;
        rn   <= in_rn;
        rd   <= in_rd;
        xa   <= in_ld;
        xb   <= in_rd;
        n    <= (operand.operation == OP_CMP) ? in_ln : '0;
        d    <= (operand.operation == OP_CMP) ? in_rn : word_t'(1);
      end
      S_MULN: if (alu_done) n <= alu_q;
      S_MULD: begin
        if (alu_done) begin
          d  <= dfix;
          xa <= n;
          xb <= dfix;
        end
      end
      S_GCDCHK: if (xa == '0) g <= xb;
      S_REMB: begin
        if (alu_done) begin
          xb <= alu_r;
          if (alu_r == '0) g <= xa;
        end
      end
      S_REMA: if (alu_done) xa <= alu_r;
      S_DIVN: if (alu_done) n <= alu_q;
      S_DIVD: begin
        if (alu_done) begin
          pass <= 1'b1;
          if (n[WIDTH-1] && dfix[WIDTH-1]) begin
            n  <= -n;
            d  <= dneg;
            xa <= -n;
            xb <= dneg;
          end else begin
            d  <= dfix;
            xa <= n;
            xb <= dfix;
          end
        end
      end
      S_CDIVG: if (alu_done) t <= alu_q;
      S_CMULM: if (alu_done) m <= alu_q[WIDTH-1] ? -alu_q : alu_q;
      S_CDIVL: if (alu_done) t <= alu_q;
      S_CMULA: if (alu_done) n <= alu_q;
      S_CDIVR: if (alu_done) t <= alu_q;
      S_CMULB: if (alu_done) d <= alu_q;
      S_OUT: begin
        if (out_free) begin
          if (op == OP_CMP) begin
            result.result_num <= '0;
            result.result_den <= 32'sd1;
            result.is_less    <= $signed(n) < $signed(d);
            result.is_equal   <= (n == d);
          end else begin
            result.result_num <= to32(n);
            result.result_den <= to32(d);
            result.is_less    <= 1'b0;
            result.is_equal   <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/rmdc_alu.sv
// Shared bit-serial unit: wrapped multiply and truncating signed divide.
module rmdc_alu import rmdc_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  alu_req_t         req,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             done,
  output logic [WIDTH-1:0] q,
  output logic [WIDTH-1:0] r
);

  localparam int CW = $clog2(WIDTH);

  logic             busy;
  logic [CW-1:0]    cnt;
  alu_op_t          kind;
  logic             neg_q;
  logic             neg_r;
  logic             zero_div;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] sh;
  logic [WIDTH-1:0] mc;
  logic [WIDTH-1:0] ub;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   rem_sub;

  assign rem_sh  = {acc, sh[WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, ub};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      kind     <= req.op;
      acc      <= '0;
      mc       <= a;
      neg_q    <= a[WIDTH-1] ^ b[WIDTH-1];
      neg_r    <= a[WIDTH-1];
      zero_div <= (b == '0);
      if (req.op == ALU_MUL) begin
        sh <= b;
        ub <= b;
      end else begin
        sh <= a[WIDTH-1] ? -a : a;
        ub <= b[WIDTH-1] ? -b : b;
      end
    end else if (busy) begin
      if (kind == ALU_MUL) begin
        if (sh[0]) begin
          acc <= acc + mc;
        end
        mc <= {mc[WIDTH-2:0], 1'b0};
        sh <= {1'b0, sh[WIDTH-1:1]};
      end else begin
        if (!rem_sub[WIDTH]) begin
          acc <= rem_sub[WIDTH-1:0];
          sh  <= {sh[WIDTH-2:0], 1'b1};
        end else begin
          acc <= rem_sh[WIDTH-1:0];
          sh  <= {sh[WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (kind == ALU_MUL) begin
      q = acc;
      r = acc;
    end else if (zero_div) begin
      q = '0;
      r = mc;
    end else begin
      q = neg_q ? -sh : sh;
      r = neg_r ? -acc : acc;
    end
  end

endmodule

### rtl/rmdc_check.sv
// Port-level checks for the rational block, bound to the top level.
`include "assert_macros.svh"

module rmdc_check import rmdc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     operand_valid,
  input logic     operand_stall,
  input operand_t operand,
  input logic     result_valid,
  input logic     result_stall,
  input result_t  result
);

  `CHK_ASSERT(a_out_hold, clk, rst, result_valid && result_stall |=> result_valid)
  `CHK_ASSERT(a_out_stable, clk, rst, result_valid && result_stall |=> $stable(result))
  `CHK_ASSERT(a_busy_after_take, clk, rst, operand_valid && !operand_stall |=> operand_stall)
  `CHK_ASSERT(a_flags_excl, clk, rst, result_valid |-> !(result.is_less && result.is_equal))
  `CHK_ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) |-> !result_valid)

endmodule

bind rational_mul_div_compare rmdc_check u_rmdc_check (
  .clk           (clk),
  .rst           (rst),
  .operand_valid (operand_valid),
  .operand_stall (operand_stall),
  .operand       (operand),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .result        (result)
);
